// ===== hdl/cml_pkg.sv =====
package cml_pkg;

    localparam int unsigned YearW  = 14;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned WdayW  = 3;

    localparam int unsigned YearMax = 9999;
    localparam int unsigned MonthMax = 12;

    // floor(y / 100) as (y * DivMul) >> DivShift, exact for y <= 16383
    localparam int unsigned DivMul   = 5243;
    localparam int unsigned DivShift = 19;
    localparam int unsigned ProdW    = YearW + 13;

    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthMar = 4'd3;
    localparam logic [WdayW-1:0]  WdaySat  = 3'd6;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_SPLIT = 5'b00100,
        S_SUM   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic div;
        logic split;
        logic sum;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic final_day;
    } t_status;

    function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                   input logic leap);
        logic [DayW-1:0] d;
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
                4'd2:                                       d = leap ? 5'd29 : 5'd28;
                default:                                    d = 5'd0;
            endcase
            return d;
        end
    endfunction

    // (13 * (m + 1)) / 5 for the shifted month 3..14
    function automatic logic [5:0] month_term(input logic [MonthW-1:0] m);
        logic [5:0] t;
        begin
            unique case (m)
                4'd3:    t = 6'd10;
                4'd4:    t = 6'd13;
                4'd5:    t = 6'd15;
                4'd6:    t = 6'd18;
                4'd7:    t = 6'd20;
                4'd8:    t = 6'd23;
                4'd9:    t = 6'd26;
                4'd10:   t = 6'd28;
                4'd11:   t = 6'd31;
                4'd12:   t = 6'd33;
                4'd13:   t = 6'd36;
                4'd14:   t = 6'd39;
                default: t = 6'd0;
            endcase
            return t;
        end
    endfunction

    // 8 = 1 mod 7, so octal digits fold down
    function automatic logic [WdayW-1:0] mod7(input logic [9:0] a);
        logic [4:0] s1;
        logic [3:0] s2;
        begin
            s1 = 5'(a[2:0]) + 5'(a[5:3]) + 5'(a[8:6]) + 5'(a[9]);
            s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
            if (s2 >= 4'd7) begin
                s2 = s2 - 4'd7;
            end
            return s2[2:0];
        end
    endfunction

endpackage

// ===== hdl/cml_ctrl.sv =====
module cml_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  cml_pkg::t_status  i_status,
    output cml_pkg::t_cmd     o_cmd
);

    cml_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cml_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            cml_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = cml_pkg::S_DIV;
                end
            end
            cml_pkg::S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = cml_pkg::S_SPLIT;
            end
            cml_pkg::S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = cml_pkg::S_SUM;
            end
            cml_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = cml_pkg::S_EMIT;
            end
            cml_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.out_free && i_status.final_day) begin
                    n_state = cml_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cml_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/cml_dp.sv =====
module cml_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cml_pkg::t_cmd                     i_cmd,
    output cml_pkg::t_status                  o_status,
    input  logic [cml_pkg::YearW-1:0]         i_year,
    input  logic [cml_pkg::MonthW-1:0]        i_month,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_valid_res,
    output logic [cml_pkg::DayW-1:0]          o_day,
    output logic [cml_pkg::WdayW-1:0]         o_weekday,
    output logic                              o_row_end,
    output logic                              o_last,
    output logic                              o_leap_year,
    output logic [cml_pkg::DayW-1:0]          o_month_length,
    output logic [cml_pkg::WdayW-1:0]         o_first_weekday
);

    logic [cml_pkg::YearW-1:0]  r_year;
    logic [cml_pkg::MonthW-1:0] r_month;
    logic                       r_ok;
    logic [cml_pkg::ProdW-1:0]  r_prod;
    logic [6:0]                 r_j, r_k;
    logic [cml_pkg::MonthW-1:0] r_mm;
    logic                       r_leap;
    logic [cml_pkg::DayW-1:0]   r_len;
    logic [cml_pkg::WdayW-1:0]  r_first;
    logic [cml_pkg::DayW-1:0]   r_day;
    logic [cml_pkg::WdayW-1:0]  r_wd;
    logic                       r_out_valid;

    logic                       out_free;
    logic [6:0]                 j0, k0;
    logic [cml_pkg::YearW-1:0]  rem_full;
    logic                       early;
    logic [9:0]                 h_sum;
    logic [cml_pkg::WdayW-1:0]  h;

    assign out_free = !r_out_valid || !i_stall;
    assign o_status.out_free  = out_free;
    assign o_status.final_day = !r_ok || (r_day == r_len);

    // century and year-in-century of the input year
    assign j0       = r_prod[cml_pkg::DivShift +: 7];
    assign rem_full = r_year - cml_pkg::YearW'(14'(j0) * 14'd100);
    assign k0       = rem_full[6:0];
    // january and february count as months 13 and 14 of the year before
    assign early    = r_month < cml_pkg::MonthMar;

    assign h_sum = 10'd1 + 10'(cml_pkg::month_term(r_mm)) + 10'(r_k) + 10'(r_k[6:2])
                 + 10'(r_j[6:2]) + 10'(r_j) * 10'd5;
    assign h     = cml_pkg::mod7(h_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= i_year;
            r_month <= i_month;
            r_ok    <= (i_year != '0) && (i_year <= cml_pkg::YearW'(cml_pkg::YearMax))
                    && (i_month != '0) && (i_month <= cml_pkg::MonthW'(cml_pkg::MonthMax));
        end
        if (i_cmd.div) begin
            r_prod <= cml_pkg::ProdW'(r_year) * cml_pkg::ProdW'(cml_pkg::DivMul);
        end
        if (i_cmd.split) begin
            r_leap <= (k0 == '0) ? (j0[1:0] == 2'd0) : (r_year[1:0] == 2'd0);
            if (early) begin
                r_mm <= r_month + 4'd12;
                r_k  <= (k0 == '0) ? 7'd99 : k0 - 7'd1;
                r_j  <= (k0 == '0) ? j0 - 7'd1 : j0;
            end else begin
                r_mm <= r_month;
                r_k  <= k0;
                r_j  <= j0;
            end
        end
        if (i_cmd.sum) begin
            r_len   <= cml_pkg::month_days(r_month, r_leap);
            r_first <= (h == '0) ? cml_pkg::WdaySat : h - 3'd1;
            r_wd    <= (h == '0) ? cml_pkg::WdaySat : h - 3'd1;
            r_day   <= 5'd1;
        end
        if (i_cmd.emit && out_free) begin
            r_day <= r_day + 5'd1;
            r_wd  <= (r_wd == cml_pkg::WdaySat) ? '0 : r_wd + 3'd1;
            if (r_ok) begin
                o_valid_res     <= 1'b1;
                o_day           <= r_day;
                o_weekday       <= r_wd;
                o_row_end       <= (r_wd == cml_pkg::WdaySat);
                o_last          <= (r_day == r_len);
                o_leap_year     <= r_leap;
                o_month_length  <= r_len;
                o_first_weekday <= r_first;
            end else begin
                o_valid_res     <= 1'b0;
                o_day           <= '0;
                o_weekday       <= '0;
                o_row_end       <= 1'b0;
                o_last          <= 1'b1;
                o_leap_year     <= 1'b0;
                o_month_length  <= '0;
                o_first_weekday <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== hdl/calendar_month_layout_unit.sv =====
// Lays out one Gregorian month per input transfer: year (1..9999) and month (1..12)
// in, then one result transfer per day carrying day number, weekday column (Sunday
// = 0), a Saturday row-end mark, a last mark and the month-wide leap flag, length
// and first weekday. An out-of-range year or month gives one result with
// o_valid_res low and o_last high. After the input transfer the block does the weekday
// arithmetic (a constant-reciprocal divide by 100, the century split, then the Zeller
// sum folded mod 7) and then emits one day per cycle while the output is not stalled.
// The next request is taken in the cycle after the last day enters the output
// register, while that day still waits.
module calendar_month_layout_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [cml_pkg::YearW-1:0]         i_year,
    input  logic [cml_pkg::MonthW-1:0]        i_month,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_valid_res,
    output logic [cml_pkg::DayW-1:0]          o_day,
    output logic [cml_pkg::WdayW-1:0]         o_weekday,
    output logic                              o_row_end,
    output logic                              o_last,
    output logic                              o_leap_year,
    output logic [cml_pkg::DayW-1:0]          o_month_length,
    output logic [cml_pkg::WdayW-1:0]         o_first_weekday
);

    cml_pkg::t_cmd    cmd;
    cml_pkg::t_status status;

    cml_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cml_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_year          (i_year),
        .i_month         (i_month),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_valid_res     (o_valid_res),
        .o_day           (o_day),
        .o_weekday       (o_weekday),
        .o_row_end       (o_row_end),
        .o_last          (o_last),
        .o_leap_year     (o_leap_year),
        .o_month_length  (o_month_length),
        .o_first_weekday (o_first_weekday)
    );

    // a new request locks the input side while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after request transfer");

    a_day_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> (o_day != '0) && (o_day <= o_month_length))
        else $error("day outside month");

    a_last_on_final_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> (o_last == (o_day == o_month_length)))
        else $error("last mark not on final day");

    a_invalid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_last && (o_day == '0) && (o_month_length == '0))
        else $error("invalid result malformed");

    a_row_end_saturday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> (o_row_end == (o_weekday == cml_pkg::WdaySat)))
        else $error("row end not on saturday");

endmodule
